/* rtl/feic_pkg.sv */
// ----------------------------------------------------------------------------
// feic_pkg
// Shared types and constants of the four-channel edge interval capture block.
// ----------------------------------------------------------------------------
package feic_pkg;

    localparam int ELAPSED_W = 22;

    localparam logic [1:0] CMD_TICK    = 2'd0;
    localparam logic [1:0] CMD_CAPTURE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    typedef struct packed {
        logic                 done_res;
        logic                 too_long;
        logic [ELAPSED_W-1:0] elapsed;
    } t_result;

endpackage

/* rtl/feic_ram.sv */
// ----------------------------------------------------------------------------
// feic_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module feic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/feic_outq.sv */
// ----------------------------------------------------------------------------
// feic_outq
// Two-entry result queue between the update stage and the output channel.
// ----------------------------------------------------------------------------
module feic_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  feic_pkg::t_result i_data,
    input  logic              i_pop,
    output feic_pkg::t_result o_data,
    output logic              o_valid,
    output logic [1:0]        o_count
);

    feic_pkg::t_result r_q [2];
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;
    logic              wslot;

    assign wslot   = (r_cnt == 2'd0) ? 1'b0 : ((r_cnt == 2'd1) ? !i_pop : 1'b1);
    assign n_cnt   = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    assign o_data  = r_q[0];
    assign o_valid = (r_cnt != 2'd0);
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !wslot) begin
            r_q[0] <= i_data;
        end else if (i_pop) begin
            r_q[0] <= r_q[1];
        end
        if (i_push && wslot) begin
            r_q[1] <= i_data;
        end
    end

endmodule

/* rtl/four_channel_edge_interval_capture.sv */
// ----------------------------------------------------------------------------
// four_channel_edge_interval_capture
// Per-channel interval measurement between two captured counter edges.
//
// Input channel (i_valid / o_ready) carries one command per transfer: an
// overflow tick for all channels, a capture edge with its counter value, or
// a read-and-clear of one channel. Every command yields exactly one result
// transfer on the output channel (o_valid / i_ready), in command order.
// Ticks and captures return all zeros; a read of a finished channel returns
// done, the too-long flag and the elapsed tick count, then frees the channel.
// Throughput is one command per cycle while o_ready is high. The start/
// interval RAM read is launched at the transfer edge, and the update,
// write-back and result queue write happen at the next edge. Channel flags
// and overflow counts sit in flops so a tick updates all channels together;
// a bypass covers a read of the entry being written back at the same edge.
// Reset leaves every channel idle; the RAM needs no clearing pass. A stalled
// receiver fills a two-entry result queue, after which o_ready drops until
// results drain.
// ----------------------------------------------------------------------------
module four_channel_edge_interval_capture #(
    parameter int CHANNELS      = 4,
    parameter int COUNTER_BITS  = 16,
    parameter int OVERFLOW_BITS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_channel,
    input  logic [15:0] i_capture_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_done_res,
    output logic        o_too_long,
    output logic [21:0] o_elapsed
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int XW = (AW > 2) ? AW : 2;
    localparam int SW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
    localparam int EW = COUNTER_BITS + OVERFLOW_BITS;
    localparam int OW = feic_pkg::ELAPSED_W;
    localparam logic [OVERFLOW_BITS-1:0] OVF_MAX = {OVERFLOW_BITS{1'b1}};

    typedef struct packed {
        logic write_start;
        logic write_interval;
        logic read_hit;
    } t_s1_op;

    logic                     fire;
    logic [XW-1:0]            chan_x;
    logic [AW-1:0]            addr;
    logic                     in_range;
    logic [SW-1:0]            cap_x;
    logic [COUNTER_BITS-1:0]  stamp;

    logic                     r_started  [CHANNELS];
    logic                     r_finished [CHANNELS];
    logic                     r_sat      [CHANNELS];
    logic [OVERFLOW_BITS-1:0] r_ovf      [CHANNELS];
    logic                     n_started  [CHANNELS];
    logic                     n_finished [CHANNELS];
    logic                     n_sat      [CHANNELS];
    logic [OVERFLOW_BITS-1:0] n_ovf      [CHANNELS];
    t_s1_op                   n_s1_op;

    logic                     r_s1_valid;
    t_s1_op                   r_s1_op;
    logic [AW-1:0]            r_s1_addr;
    logic [COUNTER_BITS-1:0]  r_s1_stamp;
    logic [OVERFLOW_BITS-1:0] r_s1_ovf;
    logic                     r_s1_sat;
    logic                     r_fwd_hit;
    logic [EW-1:0]            r_fwd_data;

    logic [EW-1:0]            ram_q;
    logic [EW-1:0]            rd_data;
    logic [EW-1:0]            total;
    logic [EW-1:0]            wdata;
    logic                     we;
    feic_pkg::t_result        s1_res;

    feic_pkg::t_result        q_data;
    logic                     q_valid;
    logic [1:0]               q_cnt;
    logic                     q_pop;
    logic [2:0]               occ;

    assign fire     = i_valid && o_ready;
    assign chan_x   = XW'(i_channel);
    assign addr     = chan_x[AW-1:0];
    assign in_range = int'(i_channel) < CHANNELS;
    assign cap_x    = SW'(i_capture_value);
    assign stamp    = cap_x[COUNTER_BITS-1:0];

    // channel flags and overflow counts
    always_comb begin
        n_started  = r_started;
        n_finished = r_finished;
        n_sat      = r_sat;
        n_ovf      = r_ovf;
        n_s1_op    = '0;
        if (fire) begin
            unique case (i_cmd)
                feic_pkg::CMD_TICK: begin
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        if (r_started[ch] && !r_finished[ch]) begin
                            if (r_ovf[ch] == OVF_MAX) begin
                                n_finished[ch] = 1'b1;
                                n_sat[ch]      = 1'b1;
                            end else begin
                                n_ovf[ch] = r_ovf[ch] + 1'b1;
                            end
                        end
                    end
                end
                feic_pkg::CMD_CAPTURE: begin
                    if (in_range && !r_finished[addr]) begin
                        if (r_started[addr]) begin
                            n_finished[addr]       = 1'b1;
                            n_s1_op.write_interval = 1'b1;
                        end else begin
                            n_started[addr]     = 1'b1;
                            n_sat[addr]         = 1'b0;
                            n_ovf[addr]         = '0;
                            n_s1_op.write_start = 1'b1;
                        end
                    end
                end
                feic_pkg::CMD_READ: begin
                    if (in_range && r_finished[addr]) begin
                        n_started[addr]  = 1'b0;
                        n_finished[addr] = 1'b0;
                        n_sat[addr]      = 1'b0;
                        n_ovf[addr]      = '0;
                        n_s1_op.read_hit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_started[ch]  <= 1'b0;
                r_finished[ch] <= 1'b0;
                r_sat[ch]      <= 1'b0;
                r_ovf[ch]      <= '0;
            end
        end else begin
            r_started  <= n_started;
            r_finished <= n_finished;
            r_sat      <= n_sat;
            r_ovf      <= n_ovf;
        end
    end

    // update stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_op    <= '0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= fire;
            r_s1_op    <= n_s1_op;
            if (fire) begin
                r_fwd_hit <= we && (r_s1_addr == addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s1_addr  <= addr;
            r_s1_stamp <= stamp;
            r_s1_ovf   <= r_ovf[addr];
            r_s1_sat   <= r_sat[addr];
            r_fwd_data <= wdata;
        end
    end

    feic_ram #(
        .WIDTH (EW),
        .DEPTH (CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s1_addr),
        .i_wdata (wdata),
        .i_re    (fire),
        .i_raddr (addr),
        .o_rdata (ram_q)
    );

    assign rd_data = r_fwd_hit ? r_fwd_data : ram_q;
    assign total   = {r_s1_ovf, {COUNTER_BITS{1'b0}}} + EW'(r_s1_stamp)
                   - EW'(rd_data[COUNTER_BITS-1:0]);
    assign wdata   = r_s1_op.write_interval ? total : EW'(r_s1_stamp);
    assign we      = r_s1_valid && (r_s1_op.write_start || r_s1_op.write_interval);

    always_comb begin
        s1_res = '0;
        if (r_s1_op.read_hit) begin
            s1_res.done_res = 1'b1;
            s1_res.too_long = r_s1_sat;
            s1_res.elapsed  = r_s1_sat ? OW'({EW{1'b1}}) : OW'(rd_data);
        end
    end

    feic_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (s1_res),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_valid (q_valid),
        .o_count (q_cnt)
    );

    assign q_pop   = q_valid && i_ready;
    assign occ     = {1'b0, q_cnt} + {2'b00, r_s1_valid};
    assign o_ready = (occ < 3'd2) || ((occ == 3'd2) && q_pop);

    assign o_valid    = q_valid;
    assign o_done_res = q_data.done_res;
    assign o_too_long = q_data.too_long;
    assign o_elapsed  = q_data.elapsed;

endmodule
